### rtl/afc_pkg.sv
// Package for the AFC ADPCM decoder: types, codes, constants and the default predictor table.
`timescale 1ns / 1ps

package afc_pkg;

  // Predictor table depth
  localparam int unsigned TableEntries = 16;

  // Field widths fixed by the stream format
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned EntryW  = 32;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned AccW    = 35;
  localparam int unsigned FracW   = 11;

  // Frame lengths in bytes, header included
  localparam logic [3:0] FrameLenNibble = 4'd9;
  localparam logic [3:0] FrameLenPair   = 4'd5;

  // Residual count per byte, less one
  localparam logic [1:0] LastIdxNibble = 2'd1;
  localparam logic [1:0] LastIdxPair   = 2'd3;

  typedef enum logic [1:0] {
    OP_STREAM  = 2'd0,
    OP_ENTRY   = 2'd1,
    OP_HISTORY = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL0 = 2'd1,
    ST_MUL1 = 2'd2,
    ST_SUM  = 2'd3
  } state_e;

  // Controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_load;
  } mac_ctrl_t;

  // Default AFC predictor pairs, c0 in the high half, c1 in the low half
  function automatic logic [EntryW-1:0] default_pair(input logic [3:0] idx);
    logic [EntryW-1:0] w;
    case (idx)
      4'd0:    w = 32'h0000_0000;
      4'd1:    w = 32'h0800_0000;
      4'd2:    w = 32'h0000_0800;
      4'd3:    w = 32'h0400_0400;
      4'd4:    w = 32'h1000_f800;
      4'd5:    w = 32'h0e00_fa00;
      4'd6:    w = 32'h0c00_fc00;
      4'd7:    w = 32'h1200_f600;
      4'd8:    w = 32'h1068_f738;
      4'd9:    w = 32'h12c0_f704;
      4'd10:   w = 32'h1400_f400;
      4'd11:   w = 32'h0800_f800;
      4'd12:   w = 32'h0400_fc00;
      4'd13:   w = 32'hfc00_0400;
      4'd14:   w = 32'hfc00_0000;
      4'd15:   w = 32'hf800_0000;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

### rtl/afc_if.sv
// Handshake interfaces for the AFC ADPCM decoder: input, result and configuration words.
`timescale 1ns / 1ps

interface afc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  stream_byte;
  logic [3:0]  entry_index;
  logic [31:0] entry_word;
  logic signed [15:0] history_newer;
  logic signed [15:0] history_older;

  modport source (output valid, opcode, stream_byte, entry_index, entry_word,
                  history_newer, history_older, input ready);
  modport sink   (input valid, opcode, stream_byte, entry_index, entry_word,
                  history_newer, history_older, output ready);
endinterface

interface afc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sample;
  logic        run_last;

  modport source (output valid, sample, run_last, input ready);
  modport sink   (input valid, sample, run_last, output ready);
endinterface

interface afc_cfg_if;
  logic valid;
  logic ready;
  logic frame_format;

  modport source (output valid, frame_format, input ready);
  modport sink   (input valid, frame_format, output ready);
endinterface

### rtl/afc_mac.sv
// Shared multiply-accumulate unit with Q11 rounding down and 16-bit saturation.
`timescale 1ns / 1ps

module afc_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  afc_pkg::mac_ctrl_t                      ctrl_i,
  input  logic signed [afc_pkg::CoefW-1:0]        coef_i,
  input  logic signed [afc_pkg::SampleW-1:0]      hist_i,
  input  logic signed [afc_pkg::AccW-1:0]         base_i,
  output logic signed [afc_pkg::SampleW-1:0]      sample_o
);

  localparam int unsigned QW = afc_pkg::AccW - afc_pkg::FracW;

  logic signed [afc_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [afc_pkg::AccW-1:0]  acc_q, acc_d;
  logic signed [afc_pkg::AccW-1:0]  sum;
  logic signed [QW-1:0]             quot;

  // Multiply into the product register
  assign prod_d = ctrl_i.mul_en ? coef_i * hist_i : prod_q;

  // Load the accumulator with the residual term plus the held product
  assign acc_d = ctrl_i.acc_load
               ? base_i + afc_pkg::AccW'(prod_q)
               : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  // Final add, floor by arithmetic shift, then clamp
  assign sum  = acc_q + afc_pkg::AccW'(prod_q);
  assign quot = QW'(sum >>> afc_pkg::FracW);

  always_comb begin
    if (quot > QW'(32767)) begin
      sample_o = 16'sh7fff;
    end else if (quot < -QW'(32768)) begin
      sample_o = 16'sh8000;
    end else begin
      sample_o = afc_pkg::SampleW'(quot);
    end
  end

endmodule

### rtl/afc_adpcm_decoder.sv
// Top level of the AFC ADPCM decoder: frame tracking, predictor table, sequencer and output word.
`timescale 1ns / 1ps

// Takes one word per handshake: a frame byte, a predictor table write, a history
// restore or a restart. A header byte, a table write, a history restore and a
// restart stay in the idle state. A residual byte yields two samples (9-byte
// frames) or four (5-byte frames); each sample passes MUL0, MUL1 and SUM on the
// one shared 16x16 multiplier and accumulator (c0 times y[n-1], c1 times y[n-2],
// then the sum and clamp). No new word is taken until the last sample of a byte
// is loaded; SUM waits while the sink stalls the output word. The last sample of
// a byte sits in the output register while the next word is taken. The
// configuration channel is always ready; write it only while the block is idle.
module afc_adpcm_decoder #(
  parameter int unsigned TABLE_ENTRIES = afc_pkg::TableEntries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  afc_in_if.sink     in_i,
  afc_cfg_if.sink    cfg_i,
  afc_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  afc_pkg::state_e state_q, state_d;

  logic [afc_pkg::EntryW-1:0] table_q [TABLE_ENTRIES];
  logic signed [15:0] hist1_q, hist1_d, hist2_q, hist2_d;
  logic [3:0]  bif_q, bif_d, bif_inc;
  logic [7:0]  header_q, header_d;
  logic        fmt_q, fmt_d;
  logic        run_fmt_q, run_fmt_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic signed [15:0] out_sample_q, out_sample_d;
  logic        out_last_q, out_last_d;

  logic        in_fire, slot_free, out_load, run_start;
  logic [3:0]  frame_len;
  logic [afc_pkg::EntryW-1:0] pair;
  logic signed [3:0]  residual;
  logic signed [afc_pkg::AccW-1:0] res_term;
  logic signed [afc_pkg::CoefW-1:0] coef;
  logic signed [15:0] hist_sel, mac_sample;
  afc_pkg::mac_ctrl_t mac_ctrl;

  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign run_start = in_fire && (afc_pkg::opcode_e'(in_i.opcode) == afc_pkg::OP_STREAM)
                     && (bif_q != 4'd0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afc_pkg::ST_IDLE: begin
        if (run_start) state_d = afc_pkg::ST_MUL0;
      end
      afc_pkg::ST_MUL0: state_d = afc_pkg::ST_MUL1;
      afc_pkg::ST_MUL1: state_d = afc_pkg::ST_SUM;
      afc_pkg::ST_SUM: begin
        if (slot_free) begin
          state_d = (cnt_q == 2'd0) ? afc_pkg::ST_IDLE : afc_pkg::ST_MUL0;
        end
      end
      default: state_d = afc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready      = 1'b0;
    mac_ctrl.mul_en   = 1'b0;
    mac_ctrl.acc_load = 1'b0;
    out_load        = 1'b0;
    coef            = pair[31:16];
    hist_sel        = hist1_q;
    case (state_q)
      afc_pkg::ST_IDLE: in_i.ready = 1'b1;
      afc_pkg::ST_MUL0: mac_ctrl.mul_en = 1'b1;
      afc_pkg::ST_MUL1: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        coef              = pair[15:0];
        hist_sel          = hist2_q;
      end
      afc_pkg::ST_SUM:  out_load = slot_free;
      default: ;
    endcase
  end

  // Predictor pair and residual of the current step
  assign pair     = table_q[header_q[IdxW-1:0]];
  assign residual = run_fmt_q ? $signed({byte_q[7:6], 2'b00}) : $signed(byte_q[7:4]);
  assign res_term = afc_pkg::AccW'(residual) <<< (5'(header_q[7:4]) + 5'(afc_pkg::FracW));

  afc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef),
    .hist_i   (hist_sel),
    .base_i   (res_term),
    .sample_o (mac_sample)
  );

  assign frame_len = fmt_q ? afc_pkg::FrameLenPair : afc_pkg::FrameLenNibble;
  assign bif_inc   = bif_q + 4'd1;

  // Frame position, history, run control and output word
  always_comb begin
    fmt_d        = cfg_i.valid ? cfg_i.frame_format : fmt_q;
    bif_d        = bif_q;
    header_d     = header_q;
    hist1_d      = hist1_q;
    hist2_d      = hist2_q;
    run_fmt_d    = run_fmt_q;
    byte_d       = byte_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;

    if (in_fire) begin
      case (afc_pkg::opcode_e'(in_i.opcode))
        afc_pkg::OP_STREAM: begin
          if (bif_q == 4'd0) begin
            header_d = in_i.stream_byte;
            bif_d    = 4'd1;
          end else begin
            byte_d    = in_i.stream_byte;
            run_fmt_d = fmt_q;
            cnt_d     = fmt_q ? afc_pkg::LastIdxPair : afc_pkg::LastIdxNibble;
            bif_d     = (bif_inc >= frame_len) ? 4'd0 : bif_inc;
          end
        end
        afc_pkg::OP_HISTORY: begin
          hist1_d = in_i.history_newer;
          hist2_d = in_i.history_older;
        end
        afc_pkg::OP_RESTART: begin
          hist1_d  = '0;
          hist2_d  = '0;
          bif_d    = '0;
          header_d = '0;
        end
        default: ;
      endcase
    end

    // Deliver a sample, advance the history and the residual
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_sample_d = mac_sample;
      out_last_d   = (cnt_q == 2'd0);
      hist2_d      = hist1_q;
      hist1_d      = mac_sample;
      byte_d       = run_fmt_q ? {byte_q[5:0], 2'b00} : {byte_q[3:0], 4'b0000};
      cnt_d        = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afc_pkg::ST_IDLE;
      hist1_q     <= '0;
      hist2_q     <= '0;
      bif_q       <= '0;
      header_q    <= '0;
      fmt_q       <= 1'b0;
      run_fmt_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hist1_q     <= hist1_d;
      hist2_q     <= hist2_d;
      bif_q       <= bif_d;
      header_q    <= header_d;
      fmt_q       <= fmt_d;
      run_fmt_q   <= run_fmt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  // Predictor table, reset to the default pairs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        table_q[i] <= afc_pkg::default_pair(4'(i));
      end
    end else if (in_fire && (afc_pkg::opcode_e'(in_i.opcode) == afc_pkg::OP_ENTRY)) begin
      table_q[in_i.entry_index[IdxW-1:0]] <= in_i.entry_word;
    end
  end

  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.sample    = out_sample_q;
  assign out_o.run_last  = out_last_q;

endmodule
